// ----- rtl/epot_pkg.sv -----
// ----------------------------------------------------------------------------
// epot_pkg
// Shared constants for the spheroid pair overlap pipeline: multiplier digit
// count and latency, configuration register widths, indexes and reset values.
// ----------------------------------------------------------------------------
package epot_pkg;

   // wide multipliers work on 32-bit digits of the second operand
   localparam int MUL_DIGITS = 4;
   // abs stage, one stage per digit, final accumulate, sign restore
   localparam int MUL_LAT    = MUL_DIGITS + 3;

   // configuration registers
   localparam int          SEMI_W      = 24;
   localparam int          CSR_IDX_W   = 1;
   localparam logic [0:0]  CSR_LONG    = 1'b0;
   localparam logic [0:0]  CSR_SHORT   = 1'b1;
   localparam logic [23:0] LONG_RESET  = 24'd131072;
   localparam logic [23:0] SHORT_RESET = 24'd65536;

endpackage

// ----- rtl/epot_dly.sv -----
// ----------------------------------------------------------------------------
// epot_dly
// Stallable delay line that keeps operands in step with the multipliers.
// ----------------------------------------------------------------------------
module epot_dly #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   import epot_pkg::*;

   logic [W-1:0] sr_ff [0:N-1];

   // shift on advance only
   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int k = 1; k < N; k++) begin
            sr_ff[k] <= sr_ff[k-1];
         end
      end
   end

   assign q = sr_ff[N-1];

endmodule

// ----- rtl/epot_mul.sv -----
// ----------------------------------------------------------------------------
// epot_mul
// Pipelined exact signed multiplier built from 32x32 digit products.
// Operand b is taken one 32-bit digit per stage.
// ----------------------------------------------------------------------------
module epot_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);
   import epot_pkg::*;

   localparam int NA  = (AW + 31) / 32;
   localparam int ND  = MUL_DIGITS;
   localparam int AMW = NA * 32;
   localparam int BMW = ND * 32;
   localparam int MW  = (NA + ND + 1) * 32;
   localparam int PW  = AW + BW;

   logic [AW-1:0]  a_abs_c;
   logic [BW-1:0]  b_abs_c;
   logic [AMW-1:0] am_ff  [0:ND-1];
   logic [BMW-1:0] bm_ff  [0:ND-1];
   logic           neg_ff [0:ND+1];
   logic [63:0]    pp_ff  [1:ND][0:NA-1];
   logic [MW-1:0]  ev_c   [1:ND];
   logic [MW-1:0]  ov_c   [1:ND];
   logic [MW-1:0]  sum_c  [1:ND];
   logic [MW-1:0]  acc_ff [2:ND+1];
   logic [MW-1:0]  neg_acc_c;
   logic [PW-1:0]  p_ff;

   // magnitudes; the most negative value maps onto its unsigned pattern
   assign a_abs_c = a[AW-1] ? AW'(~a + 1'b1) : a;
   assign b_abs_c = b[BW-1] ? BW'(~b + 1'b1) : b;

   // digit products of one row: even products do not overlap one another, nor do odd ones
   always_comb begin
      for (int k = 1; k <= ND; k++) begin
         ev_c[k] = '0;
         ov_c[k] = '0;
         for (int i = 0; i < NA; i++) begin
            if ((i & 1) == 0) begin
               ev_c[k][32*i +: 64] = pp_ff[k][i];
            end else begin
               ov_c[k][32*i +: 64] = pp_ff[k][i];
            end
         end
         sum_c[k] = (ev_c[k] + ov_c[k]) << (32 * (k - 1));
      end
   end

   assign neg_acc_c = '0 - acc_ff[ND+1];

   // digit pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         am_ff[0]  <= AMW'(a_abs_c);
         bm_ff[0]  <= BMW'(b_abs_c);
         neg_ff[0] <= a[AW-1] ^ b[BW-1];
         for (int k = 1; k < ND; k++) begin
            am_ff[k] <= am_ff[k-1];
            bm_ff[k] <= bm_ff[k-1];
         end
         for (int k = 1; k <= ND + 1; k++) begin
            neg_ff[k] <= neg_ff[k-1];
         end
         for (int k = 1; k <= ND; k++) begin
            for (int i = 0; i < NA; i++) begin
               pp_ff[k][i] <= 64'(am_ff[k-1][32*i +: 32]) *
                              64'(bm_ff[k-1][32*(k-1) +: 32]);
            end
         end
         acc_ff[2] <= sum_c[1];
         for (int k = 3; k <= ND + 1; k++) begin
            acc_ff[k] <= acc_ff[k-1] + sum_c[k-1];
         end
         p_ff <= neg_ff[ND+1] ? neg_acc_c[PW-1:0] : acc_ff[ND+1][PW-1:0];
      end
   end

   assign p = p_ff;

endmodule

// ----- rtl/ellipsoid_pair_overlap_test.sv -----
// ----------------------------------------------------------------------------
// ellipsoid_pair_overlap_test
// Gaussian-overlap contact test for two identical spheroids, exact in integers.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one pair per transfer (centres Q16.16, unit directors Q2.14).
//   rsp_*  : one overlap flag per pair, in the order the pairs were taken.
//   csr_*  : semi-axis registers (index 0 long, index 1 short, unsigned Q8.16),
//            always ready; write them only while no pair is in flight.
// Throughput: one pair per cycle while no result waits on a stalled receiver.
//   The depth is set by four chained wide products, each cut into 32x32 digit
//   products over seven stages.
// Reset clears the valid bits of every stage and of the output register and
//   loads the semi-axes with 2.0 and 1.0.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
//   req_stall is raised the same cycle; nothing is dropped or repeated.
// Coincident centres, and a zero denominator, report overlap.
// ----------------------------------------------------------------------------
module ellipsoid_pair_overlap_test (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_first_x,
   input  logic signed [31:0]                req_first_y,
   input  logic signed [31:0]                req_first_z,
   input  logic signed [31:0]                req_second_x,
   input  logic signed [31:0]                req_second_y,
   input  logic signed [31:0]                req_second_z,
   input  logic signed [15:0]                req_first_dir_x,
   input  logic signed [15:0]                req_first_dir_y,
   input  logic signed [15:0]                req_first_dir_z,
   input  logic signed [15:0]                req_second_dir_x,
   input  logic signed [15:0]                req_second_dir_y,
   input  logic signed [15:0]                req_second_dir_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_overlaps,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [epot_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [epot_pkg::SEMI_W-1:0]       csr_data
);
   import epot_pkg::*;

   localparam int DEPTH = 4 * MUL_LAT + 4;

   logic adv;

   // configuration
   logic [SEMI_W-1:0] long_ff, short_ff;

   // input stage
   logic signed [32:0] d_ff  [0:2];
   logic signed [15:0] u1_ff [0:2];
   logic signed [15:0] u2_ff [0:2];
   logic signed [24:0] a0_ff, b0_ff;
   logic               vld_ff [0:DEPTH];

   // first products
   logic signed [49:0] aa_w, bb_w;
   logic signed [48:0] pm_w [0:2];
   logic signed [48:0] qm_w [0:2];
   logic signed [65:0] dsq_w [0:2];
   logic signed [31:0] num_w [0:2];

   // first sums
   logic signed [50:0] s_ff, t_ff, p_ff, q_ff;
   logic signed [33:0] nu_ff;
   logic signed [68:0] r4_ff;

   // second products
   logic signed [101:0] ss_w, tt_w, ts_w, pp_w, qq_w, pq_w;
   logic signed [67:0]  nn_w;
   logic signed [68:0]  r4_d;
   logic signed [33:0]  nu_d;

   // second sums
   logic signed [102:0] pq2_ff;
   logic signed [101:0] ss2_ff, tt2_ff, ts2_ff, pqv_ff;
   logic signed [67:0]  nn2_ff;
   logic signed [68:0]  r4b_ff;
   logic signed [33:0]  nub_ff;

   // third products
   logic signed [169:0] ttnn_w;
   logic signed [204:0] tspq2_w;
   logic signed [135:0] nupq_w;
   logic signed [101:0] ss_d, tt_d;
   logic signed [68:0]  r4b_d;

   // denominator stage
   logic signed [170:0] e_ff;
   logic signed [101:0] tt3_ff;
   logic signed [68:0]  r4c_ff;
   logic signed [204:0] tspq2_ff;
   logic signed [135:0] nupq_ff;
   logic [1:0]          ef_c, ef_d;

   // fourth products
   logic signed [239:0] er_w;
   logic signed [237:0] ttnupq_w;
   logic signed [204:0] tspq2_d;

   // final sum and decision
   logic signed [241:0] f_ff;
   logic                e_neg_ff, e_zero_ff;
   logic                coin_c, coin_d;
   logic                hit_c;
   logic                rsp_valid_ff, rsp_overlaps_ff;

   // whole pipeline moves unless a result waits on a stalled receiver
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // semi-axis registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff  <= LONG_RESET;
         short_ff <= SHORT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LONG: begin
               long_ff <= csr_data;
            end
            CSR_SHORT: begin
               short_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // valid bits travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // input stage: centre difference, directors, semi-axes
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0]  <= 33'(req_second_x) - 33'(req_first_x);
         d_ff[1]  <= 33'(req_second_y) - 33'(req_first_y);
         d_ff[2]  <= 33'(req_second_z) - 33'(req_first_z);
         u1_ff[0] <= req_first_dir_x;
         u1_ff[1] <= req_first_dir_y;
         u1_ff[2] <= req_first_dir_z;
         u2_ff[0] <= req_second_dir_x;
         u2_ff[1] <= req_second_dir_y;
         u2_ff[2] <= req_second_dir_z;
         a0_ff    <= {1'b0, long_ff};
         b0_ff    <= {1'b0, short_ff};
      end
   end

   // coincident centres flag rides to the decision stage
   assign coin_c = (d_ff[0] == '0) && (d_ff[1] == '0) && (d_ff[2] == '0);

   epot_dly #(.W(1), .N(DEPTH)) u_coin_dly (
      .clock(clock), .en(adv), .d(coin_c), .q(coin_d)
   );

   // first products: squares of semi-axes, projections, distances, nu terms
   epot_mul #(.AW(25), .BW(25)) u_aa (
      .clock(clock), .en(adv), .a(a0_ff), .b(a0_ff), .p(aa_w)
   );
   epot_mul #(.AW(25), .BW(25)) u_bb (
      .clock(clock), .en(adv), .a(b0_ff), .b(b0_ff), .p(bb_w)
   );

   for (genvar g = 0; g < 3; g++) begin : g_axis
      epot_mul #(.AW(33), .BW(16)) u_p (
         .clock(clock), .en(adv), .a(d_ff[g]), .b(u1_ff[g]), .p(pm_w[g])
      );
      epot_mul #(.AW(33), .BW(16)) u_q (
         .clock(clock), .en(adv), .a(d_ff[g]), .b(u2_ff[g]), .p(qm_w[g])
      );
      epot_mul #(.AW(33), .BW(33)) u_dsq (
         .clock(clock), .en(adv), .a(d_ff[g]), .b(d_ff[g]), .p(dsq_w[g])
      );
      epot_mul #(.AW(16), .BW(16)) u_nu (
         .clock(clock), .en(adv), .a(u1_ff[g]), .b(u2_ff[g]), .p(num_w[g])
      );
   end

   // first sums: S, T, nu, p, q and R^2 - 4b^2
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff  <= 51'(aa_w) + 51'(bb_w);
         t_ff  <= 51'(aa_w) - 51'(bb_w);
         nu_ff <= 34'(num_w[0]) + 34'(num_w[1]) + 34'(num_w[2]);
         p_ff  <= 51'(pm_w[0]) + 51'(pm_w[1]) + 51'(pm_w[2]);
         q_ff  <= 51'(qm_w[0]) + 51'(qm_w[1]) + 51'(qm_w[2]);
         r4_ff <= 69'(dsq_w[0]) + 69'(dsq_w[1]) + 69'(dsq_w[2]) - (69'(bb_w) <<< 2);
      end
   end

   // second products
   epot_mul #(.AW(51), .BW(51)) u_ss (
      .clock(clock), .en(adv), .a(s_ff), .b(s_ff), .p(ss_w)
   );
   epot_mul #(.AW(51), .BW(51)) u_tt (
      .clock(clock), .en(adv), .a(t_ff), .b(t_ff), .p(tt_w)
   );
   epot_mul #(.AW(51), .BW(51)) u_ts (
      .clock(clock), .en(adv), .a(t_ff), .b(s_ff), .p(ts_w)
   );
   epot_mul #(.AW(51), .BW(51)) u_pp (
      .clock(clock), .en(adv), .a(p_ff), .b(p_ff), .p(pp_w)
   );
   epot_mul #(.AW(51), .BW(51)) u_qq (
      .clock(clock), .en(adv), .a(q_ff), .b(q_ff), .p(qq_w)
   );
   epot_mul #(.AW(51), .BW(51)) u_pq (
      .clock(clock), .en(adv), .a(p_ff), .b(q_ff), .p(pq_w)
   );
   epot_mul #(.AW(34), .BW(34)) u_nn (
      .clock(clock), .en(adv), .a(nu_ff), .b(nu_ff), .p(nn_w)
   );
   epot_dly #(.W(69), .N(MUL_LAT)) u_r4_dly (
      .clock(clock), .en(adv), .d(r4_ff), .q(r4_d)
   );
   epot_dly #(.W(34), .N(MUL_LAT)) u_nu_dly (
      .clock(clock), .en(adv), .d(nu_ff), .q(nu_d)
   );

   // second sums: p^2 + q^2, the rest passes through
   always_ff @(posedge clock) begin
      if (adv) begin
         pq2_ff <= 103'(pp_w) + 103'(qq_w);
         ss2_ff <= ss_w;
         tt2_ff <= tt_w;
         ts2_ff <= ts_w;
         pqv_ff <= pq_w;
         nn2_ff <= nn_w;
         r4b_ff <= r4_d;
         nub_ff <= nu_d;
      end
   end

   // third products
   epot_mul #(.AW(102), .BW(68)) u_ttnn (
      .clock(clock), .en(adv), .a(tt2_ff), .b(nn2_ff), .p(ttnn_w)
   );
   epot_mul #(.AW(103), .BW(102)) u_tspq2 (
      .clock(clock), .en(adv), .a(pq2_ff), .b(ts2_ff), .p(tspq2_w)
   );
   epot_mul #(.AW(102), .BW(34)) u_nupq (
      .clock(clock), .en(adv), .a(pqv_ff), .b(nub_ff), .p(nupq_w)
   );
   epot_dly #(.W(102), .N(MUL_LAT)) u_ss_dly (
      .clock(clock), .en(adv), .d(ss2_ff), .q(ss_d)
   );
   epot_dly #(.W(102), .N(MUL_LAT)) u_tt_dly (
      .clock(clock), .en(adv), .d(tt2_ff), .q(tt_d)
   );
   epot_dly #(.W(69), .N(MUL_LAT)) u_r4b_dly (
      .clock(clock), .en(adv), .d(r4b_ff), .q(r4b_d)
   );

   // common denominator E = S^2 * 2^56 - T^2 nu^2
   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff     <= (171'(ss_d) <<< 56) - 171'(ttnn_w);
         tt3_ff   <= tt_d;
         r4c_ff   <= r4b_d;
         tspq2_ff <= tspq2_w;
         nupq_ff  <= nupq_w;
      end
   end

   // sign of E and whether E is zero, kept for the decision
   assign ef_c = {e_ff[170], (e_ff == '0)};

   epot_dly #(.W(2), .N(MUL_LAT)) u_ef_dly (
      .clock(clock), .en(adv), .d(ef_c), .q(ef_d)
   );

   // fourth products
   epot_mul #(.AW(171), .BW(69)) u_er (
      .clock(clock), .en(adv), .a(e_ff), .b(r4c_ff), .p(er_w)
   );
   epot_mul #(.AW(136), .BW(102)) u_ttnupq (
      .clock(clock), .en(adv), .a(nupq_ff), .b(tt3_ff), .p(ttnupq_w)
   );
   epot_dly #(.W(205), .N(MUL_LAT)) u_tspq2_dly (
      .clock(clock), .en(adv), .d(tspq2_ff), .q(tspq2_d)
   );

   // numerator F = E(R^2-4b^2) - 2^28 T S (p^2+q^2) + 2 T^2 nu p q
   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff      <= 242'(er_w) - (242'(tspq2_d) <<< 28) + (242'(ttnupq_w) <<< 1);
         e_neg_ff  <= ef_d[1];
         e_zero_ff <= ef_d[0];
      end
   end

   // R^2 D < 4b^2, flipped for negative E; coincident centres or zero E also hit
   assign hit_c = coin_d || e_zero_ff ||
                  (!e_neg_ff && f_ff[241]) ||
                  (e_neg_ff && !f_ff[241] && (f_ff != '0));

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_overlaps_ff <= hit_c;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overlaps = rsp_overlaps_ff;

endmodule
